// ===== hdl/smvz_pkg.sv =====
// Shared constants, register indexes and status codes of the z-test core.
`default_nettype none
package smvz_pkg;
  localparam int unsigned MAX_SAMPLES_DEF = 128;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;
  localparam int unsigned CFG_W           = 16;
  localparam logic [CFG_W-1:0] HYP_MEAN_RESET = 16'h0000;
  localparam logic [CFG_W-1:0] CRIT_RESET     = 16'd502;
  localparam int unsigned MEAN_W = 16;
  localparam int unsigned VAR_W  = 32;
  localparam int unsigned Z_W    = 16;
  localparam int unsigned USED_W = 8;

  typedef enum logic [0:0] {
    REG_HYP_MEAN = 1'b0,
    REG_CRIT_VAL = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FEW      = 2'd1,
    ST_ZERO_VAR = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;
endpackage
`default_nettype wire

// ===== hdl/smvz_if.sv =====
// Valid/ready channel interfaces for samples and results.
`default_nettype none
interface smvz_in_if #(
  parameter int unsigned SAMPLE_BITS = smvz_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface smvz_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [smvz_pkg::MEAN_W-1:0]  mean_value;
  logic        [smvz_pkg::VAR_W-1:0]   sample_variance;
  logic        [smvz_pkg::Z_W-1:0]     z_magnitude;
  logic                                z_negative;
  logic                                reject_null;
  logic        [smvz_pkg::USED_W-1:0]  samples_used;
  logic        [1:0]                   status_code;
  modport source (output valid, mean_value, sample_variance, z_magnitude, z_negative,
                  reject_null, samples_used, status_code, input ready);
  modport sink   (input valid, mean_value, sample_variance, z_magnitude, z_negative,
                  reject_null, samples_used, status_code, output ready);
endinterface
`default_nettype wire

// ===== hdl/smvz_front.sv =====
// Front end: accepts samples, fills the sample store and keeps count and running sum.
`default_nettype none
module smvz_front #(
  parameter int unsigned MAX_SAMPLES = smvz_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = smvz_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int unsigned SW = SAMPLE_BITS + CW,
  localparam int unsigned JW = 1 + CW + SW
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  smvz_in_if.sink                            in_i,
  input  wire logic                          store_busy_i,
  output logic                               push_o,
  output logic        [JW-1:0]               job_o,
  input  wire logic   [AW-1:0]               rd_addr_i,
  output logic signed [SAMPLE_BITS-1:0]      rd_data_o
);
  logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic        [CW-1:0]          count_q, count_d;
  logic signed [SW-1:0]          sum_q, sum_d;
  logic                          ovf_q, ovf_d;
  logic                          accept, has_room;

  assign in_i.ready = !store_busy_i;
  assign accept     = in_i.valid && in_i.ready;
  assign has_room   = count_q < CW'(MAX_SAMPLES);

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    if (has_room) begin
      count_d = count_q + 1'b1;
      sum_d   = sum_q + SW'(in_i.sample);
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_o = accept && in_i.last_sample;
  assign job_o  = {ovf_d, count_d, sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      if (in_i.last_sample) begin
        count_q <= '0;
        sum_q   <= '0;
        ovf_q   <= 1'b0;
      end else begin
        count_q <= count_d;
        sum_q   <= sum_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_room) begin
      mem[count_q[AW-1:0]] <= in_i.sample;
    end
    rd_data_o <= mem[rd_addr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/smvz_queue.sv =====
// Two-entry job queue between the front end and the back end.
`default_nettype none
module smvz_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic      [W-1:0] data_o
);
  logic [W-1:0] slot_q [2];
  logic [1:0]   cnt_q;
  logic         wr_q, rd_q;
  logic         do_push, do_pop;

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= data_i;
  end
endmodule
`default_nettype wire

// ===== hdl/smvz_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module smvz_div #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              done_o,
  output logic      [W-1:0] quo_o
);
  localparam int unsigned KW = $clog2(W + 1);

  logic [W-1:0]  rem_q, quo_q, den_q;
  logic [KW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [W:0]    trial;
  logic          ge;

  assign trial  = {rem_q, quo_q[W-1]};
  assign ge     = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= KW'(W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == KW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/smvz_back.sv =====
// Back end: mean, second pass for the variance, z statistic and result register.
`default_nettype none
module smvz_back #(
  parameter int unsigned MAX_SAMPLES = smvz_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = smvz_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int unsigned SW = SAMPLE_BITS + CW,
  localparam int unsigned JW = 1 + CW + SW
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  input  wire logic        [JW-1:0]           job_i,
  output logic                                pop_o,
  output logic                                store_busy_o,
  output logic             [AW-1:0]           rd_addr_o,
  input  wire logic signed [SAMPLE_BITS-1:0]  rd_data_i,
  input  wire logic signed [smvz_pkg::CFG_W-1:0] hyp_mean_i,
  input  wire logic        [smvz_pkg::CFG_W-1:0] crit_i,
  smvz_out_if.source                          out_o
);
  localparam int unsigned MW   = SAMPLE_BITS + 1;
  localparam int unsigned AMW  = SAMPLE_BITS + 1;
  localparam int unsigned DFW  = SAMPLE_BITS + 2;
  localparam int unsigned TW   = 2 * AMW + CW;
  localparam int unsigned NTW  = TW + CW;
  localparam int unsigned NMW  = CW + 1 + MW;
  localparam int unsigned RW   = ((SW > NMW) ? SW : NMW) + 1;
  localparam int unsigned DENW = 2 * CW;
  localparam int unsigned NHW  = CW + 1 + smvz_pkg::CFG_W;
  localparam int unsigned DDW  = ((SW > NHW) ? SW : NHW) + 1;
  localparam int unsigned QNW  = 2 * DDW + 16;
  localparam int unsigned SQW  = QNW + (QNW % 2);
  localparam int unsigned NVW  = CW + smvz_pkg::VAR_W;
  localparam int unsigned DIVW = (QNW > NTW) ? QNW : NTW;
  localparam int unsigned VW   = smvz_pkg::VAR_W;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_MEAN = 14'b00000000000010,
    S_PASS = 14'b00000000000100,
    S_VM1  = 14'b00000000001000,
    S_VM2  = 14'b00000000010000,
    S_VM3  = 14'b00000000100000,
    S_VM4  = 14'b00000001000000,
    S_VARW = 14'b00000010000000,
    S_ZM1  = 14'b00000100000000,
    S_ZM2  = 14'b00001000000000,
    S_ZM3  = 14'b00010000000000,
    S_ZM4  = 14'b00100000000000,
    S_ZW   = 14'b01000000000000,
    S_SQRT = 14'b10000000000000
  } state_e;

  state_e                state_q;
  logic        [CW-1:0]  n_q, iss_q;
  logic signed [SW-1:0]  sum_q;
  logic                  ovf_q;
  logic signed [MW-1:0]  mean_q;
  logic                  dv_q, sqv_q;
  logic      [2*AMW-1:0] sq_q;
  logic        [TW-1:0]  t_q;
  logic        [NTW-1:0] nt_q;
  logic signed [NMW-1:0] nm_q;
  logic       [DENW-1:0] den_q;
  logic        [RW-1:0]  rmag_q;
  logic      [2*RW-1:0]  rsq_q;
  logic        [VW-1:0]  var_q;
  logic signed [NHW-1:0] nh_q;
  logic        [NVW-1:0] nv_q;
  logic        [DDW-1:0] dmag_q;
  logic                  neg_q;
  logic     [2*DDW-1:0]  dsq_q;
  logic        [SQW-1:0] sv_q, sr_q, sb_q;
  logic                  out_valid_q;

  logic                  j_ovf;
  logic        [CW-1:0]  j_n;
  logic signed [SW-1:0]  j_sum;
  logic        [SW-1:0]  j_abs;
  logic                  div_start, div_done;
  logic      [DIVW-1:0]  div_num, div_den, div_quo;
  logic signed [DFW-1:0] diff_w;
  logic        [AMW-1:0] amag_w;
  logic signed [RW-1:0]  r_w;
  logic signed [DDW-1:0] d_w;
  logic        [VW-1:0]  var_w;
  logic        [SQW-1:0] ssum_w;
  logic [smvz_pkg::Z_W-1:0] zq_w;

  assign j_ovf = job_i[JW-1];
  assign j_n   = job_i[JW-2 -: CW];
  assign j_sum = job_i[SW-1:0];
  assign j_abs = j_sum[SW-1] ? SW'(-j_sum) : SW'(j_sum);

  assign rd_addr_o    = iss_q[AW-1:0];
  assign store_busy_o = (state_q == S_MEAN) || (state_q == S_PASS);
  assign out_o.valid  = out_valid_q;

  assign diff_w = DFW'(rd_data_i) - DFW'(mean_q);
  assign amag_w = diff_w[DFW-1] ? AMW'(-diff_w) : AMW'(diff_w);
  assign r_w    = RW'(sum_q) - RW'(nm_q);
  assign d_w    = DDW'(sum_q) - DDW'(nh_q);
  assign var_w  = (|div_quo[DIVW-1:VW]) ? '1 : div_quo[VW-1:0];
  assign ssum_w = sr_q + sb_q;
  assign zq_w   = (|sr_q[SQW-1:smvz_pkg::Z_W]) ? '1 : sr_q[smvz_pkg::Z_W-1:0];

  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          pop_o = 1'b1;
          if (j_n >= CW'(2)) begin
            div_start = 1'b1;
            div_num   = DIVW'(j_abs);
            div_den   = DIVW'(j_n);
          end
        end
      end
      S_VM4: begin
        div_start = 1'b1;
        div_num   = DIVW'(nt_q - NTW'(rsq_q));
        div_den   = DIVW'(den_q);
      end
      S_ZM4: begin
        div_start = 1'b1;
        div_num   = DIVW'({dsq_q, 16'h0000});
        div_den   = DIVW'(nv_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  smvz_div #(
    .W(DIVW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      sqv_q       <= 1'b0;
    end else begin
      dv_q  <= (state_q == S_PASS) && (iss_q != n_q);
      sqv_q <= dv_q;
      if (dv_q)  sq_q <= amag_w * amag_w;
      if (sqv_q) t_q  <= t_q + TW'(sq_q);
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (q_valid_i && !out_valid_q) begin
            n_q   <= j_n;
            sum_q <= j_sum;
            ovf_q <= j_ovf;
            if (j_n < CW'(2)) begin
              out_o.mean_value      <= (j_n == CW'(1)) ? 16'(j_sum) : '0;
              out_o.sample_variance <= '0;
              out_o.z_magnitude     <= '0;
              out_o.z_negative      <= 1'b0;
              out_o.reject_null     <= 1'b0;
              out_o.samples_used    <= 8'(j_n);
              out_o.status_code     <= smvz_pkg::ST_FEW;
              out_valid_q           <= 1'b1;
            end else begin
              state_q <= S_MEAN;
            end
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean_q  <= sum_q[SW-1] ? -MW'(div_quo) : MW'(div_quo);
            iss_q   <= '0;
            t_q     <= '0;
            state_q <= S_PASS;
          end
        end
        S_PASS: begin
          if (iss_q != n_q) begin
            iss_q <= iss_q + 1'b1;
          end else if (!dv_q && !sqv_q) begin
            state_q <= S_VM1;
          end
        end
        S_VM1: begin
          nt_q    <= NTW'(n_q) * NTW'(t_q);
          nm_q    <= $signed({1'b0, n_q}) * mean_q;
          den_q   <= DENW'(n_q) * DENW'(n_q - 1'b1);
          state_q <= S_VM2;
        end
        S_VM2: begin
          rmag_q  <= r_w[RW-1] ? RW'(-r_w) : RW'(r_w);
          state_q <= S_VM3;
        end
        S_VM3: begin
          rsq_q   <= (2 * RW)'(rmag_q) * (2 * RW)'(rmag_q);
          state_q <= S_VM4;
        end
        S_VM4: begin
          state_q <= S_VARW;
        end
        S_VARW: begin
          if (div_done) begin
            var_q <= var_w;
            if (var_w == '0) begin
              out_o.mean_value      <= 16'(mean_q);
              out_o.sample_variance <= '0;
              out_o.z_magnitude     <= '0;
              out_o.z_negative      <= 1'b0;
              out_o.reject_null     <= 1'b0;
              out_o.samples_used    <= 8'(n_q);
              out_o.status_code     <= ovf_q ? smvz_pkg::ST_OVERFLOW : smvz_pkg::ST_ZERO_VAR;
              out_valid_q           <= 1'b1;
              state_q               <= S_IDLE;
            end else begin
              state_q <= S_ZM1;
            end
          end
        end
        S_ZM1: begin
          nh_q    <= $signed({1'b0, n_q}) * hyp_mean_i;
          nv_q    <= NVW'(n_q) * NVW'(var_q);
          state_q <= S_ZM2;
        end
        S_ZM2: begin
          dmag_q  <= d_w[DDW-1] ? DDW'(-d_w) : DDW'(d_w);
          neg_q   <= d_w[DDW-1];
          state_q <= S_ZM3;
        end
        S_ZM3: begin
          dsq_q   <= (2 * DDW)'(dmag_q) * (2 * DDW)'(dmag_q);
          state_q <= S_ZM4;
        end
        S_ZM4: begin
          state_q <= S_ZW;
        end
        S_ZW: begin
          if (div_done) begin
            sv_q    <= SQW'(div_quo);
            sr_q    <= '0;
            sb_q    <= SQW'(1) << (SQW - 2);
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sb_q != '0) begin
            if (sv_q >= ssum_w) begin
              sv_q <= sv_q - ssum_w;
              sr_q <= (sr_q >> 1) + sb_q;
            end else begin
              sr_q <= sr_q >> 1;
            end
            sb_q <= sb_q >> 2;
          end else begin
            out_o.mean_value      <= 16'(mean_q);
            out_o.sample_variance <= var_q;
            out_o.z_magnitude     <= zq_w;
            out_o.z_negative      <= neg_q;
            out_o.reject_null     <= zq_w > crit_i;
            out_o.samples_used    <= 8'(n_q);
            out_o.status_code     <= ovf_q ? smvz_pkg::ST_OVERFLOW : smvz_pkg::ST_OK;
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sample_mean_variance_z_test_core.sv =====
// Top level of the one-sample z-test core: register port, front end, job queue, back end.
// The core takes signed Q8.8 samples one item per cycle while the input is not stalled,
// stores up to MAX_SAMPLES of each set and keeps a running sum of them; the item flagged
// last_sample closes the data set and yields exactly one result item with the mean, the
// sample variance (Q16.16, saturating), |z| in Q8.8, the sign of z, the reject decision
// against critical_value and a status code. The back end then spends, for a set of n
// samples, one division for the mean, a second pass over the store, a division for the
// variance, a division for z squared and a bit-pair square root. The sample store is free
// again once the second pass ends, so the front end loads the next set while the back end
// finishes the current one. Sets of fewer than two samples are answered straight from the
// idle state, with no division. The result waits in an output register; while it is not
// taken the back end starts no new set, so the next closed set waits in the queue and the
// input stalls once that set's last sample is in. hypothesised_mean sits at byte address 0
// and critical_value at byte address 4; write them only while the core is idle.
`default_nettype none
module sample_mean_variance_z_test_core #(
  parameter int unsigned MAX_SAMPLES = smvz_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = smvz_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  smvz_in_if.sink                                in_i,
  smvz_out_if.source                             out_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [smvz_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [smvz_pkg::PDATA_W-1:0]      pwdata,
  output logic      [smvz_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready
);
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned SW = SAMPLE_BITS + CW;
  localparam int unsigned JW = 1 + CW + SW;

  // Configuration registers; the index is the word address bit.
  logic [smvz_pkg::CFG_W-1:0] hyp_mean_q, crit_q;
  smvz_pkg::reg_idx_e         reg_idx;
  logic                       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = smvz_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyp_mean_q <= smvz_pkg::HYP_MEAN_RESET;
      crit_q     <= smvz_pkg::CRIT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        smvz_pkg::REG_HYP_MEAN: hyp_mean_q <= pwdata[smvz_pkg::CFG_W-1:0];
        smvz_pkg::REG_CRIT_VAL: crit_q     <= pwdata[smvz_pkg::CFG_W-1:0];
        default:                crit_q     <= crit_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      smvz_pkg::REG_HYP_MEAN: prdata = smvz_pkg::PDATA_W'(hyp_mean_q);
      smvz_pkg::REG_CRIT_VAL: prdata = smvz_pkg::PDATA_W'(crit_q);
      default:                prdata = '0;
    endcase
  end

  // The front end stalls while a closed set waits in the queue or the back end still reads
  // the store, since the next set overwrites it.
  logic                          push, pop, q_valid, back_store_busy, store_busy;
  logic [JW-1:0]                 job_in, job_out;
  logic [AW-1:0]                 rd_addr;
  logic signed [SAMPLE_BITS-1:0] rd_data;

  assign store_busy = q_valid || back_store_busy;

  smvz_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .store_busy_i (store_busy),
    .push_o       (push),
    .job_o        (job_in),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data)
  );

  smvz_queue #(
    .W (JW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  smvz_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .job_i        (job_out),
    .pop_o        (pop),
    .store_busy_o (back_store_busy),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .hyp_mean_i   (hyp_mean_q),
    .crit_i       (crit_q),
    .out_o        (out_o)
  );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the one-sample z-test core.
`timescale 1ns / 100ps
module testbench;
  localparam int unsigned NMAX = smvz_pkg::MAX_SAMPLES_DEF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [smvz_pkg::PADDR_W-1:0] paddr = '0;
  logic [smvz_pkg::PDATA_W-1:0] pwdata = '0;
  logic [smvz_pkg::PDATA_W-1:0] prdata;
  logic pready;

  smvz_in_if  smp_ch ();
  smvz_out_if res_ch ();

  sample_mean_variance_z_test_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(smp_ch.sink), .out_o(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk_i = ~clk_i;

  // One result item of the core, as the checker compares it.
  typedef struct packed {
    logic signed [15:0] mean;
    logic [31:0]        variance;
    logic [15:0]        zmag;
    logic               zneg;
    logic               reject;
    logic [7:0]         used;
    smvz_pkg::status_e  status;
  } zres_t;

  // Predictor state: our own copy of the store and of the registers.
  longint signed set_store [NMAX];
  int unsigned   set_count;
  longint signed set_sum;
  bit            set_overflow;
  logic signed [15:0] hyp_mean_q;
  logic [15:0]        crit_q;

  zres_t expected_results[$];
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned sets_sent;
  int unsigned overflow_sets;
  int unsigned reject_sets;
  bit hold_results;   // receiver holds off while this is set

  function automatic longint unsigned abs64(longint signed v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // Integer square root, bit-pair method, floor.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Feeds one sample into the predictor; returns 1 and fills res when the set closes.
  function automatic bit predict_z_test(logic signed [15:0] x, bit last, output zres_t res);
    longint unsigned n, sq, num, var_v, q, zq, rr, dm, a;
    longint signed mean, rem, d;
    res = '0;
    if (set_count < NMAX) begin
      set_store[set_count] = x;
      set_count++;
      set_sum += x;
    end else begin
      set_overflow = 1'b1;
    end
    if (!last) return 1'b0;
    n = set_count;
    if (n < 2) begin
      res.status = smvz_pkg::ST_FEW;
      res.mean = (n == 1) ? set_sum[15:0] : 16'sd0;
    end else begin
      mean = set_sum / longint'(n);
      sq = 0;
      for (int i = 0; i < set_count; i++) begin
        a = abs64(set_store[i] - mean);
        sq += a * a;
      end
      rem = set_sum - longint'(n) * mean;
      rr = abs64(rem);
      num = n * sq - rr * rr;
      var_v = num / (n * (n - 1));
      if (var_v > 64'hFFFF_FFFF) var_v = 64'hFFFF_FFFF;
      res.mean = mean[15:0];
      res.variance = var_v[31:0];
      res.status = set_overflow ? smvz_pkg::ST_OVERFLOW :
                   (var_v == 0 ? smvz_pkg::ST_ZERO_VAR : smvz_pkg::ST_OK);
      if (var_v != 0) begin
        d = set_sum - longint'(n) * longint'(hyp_mean_q);
        dm = abs64(d);
        q = (64'd65536 * dm * dm) / (n * var_v);
        zq = int_sqrt(q);
        if (zq > 64'hFFFF) zq = 64'hFFFF;
        res.zmag = zq[15:0];
        res.zneg = d < 0;
        res.reject = zq > crit_q;
      end
    end
    res.used = n[7:0];
    set_count = 0;
    set_sum = 0;
    set_overflow = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Sample channel driver. Each accepted item goes through the predictor.
  task automatic send_sample(input logic signed [15:0] x, input bit last, input bit gaps);
    zres_t res;
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (($urandom_range(0, 3) == 0)) gap = 0;
    if (gap != 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_ch.valid <= 1'b1;
    smp_ch.sample <= x;
    smp_ch.last_sample <= last;
    @(posedge clk_i);
    while (!smp_ch.ready) @(posedge clk_i);
    if (predict_z_test(x, last, res)) begin
      expected_results.push_back(res);
      sets_sent++;
      if (res.status == smvz_pkg::ST_OVERFLOW) overflow_sets++;
      if (res.reject) reject_sets++;
    end
  endtask

  task automatic idle_sender();
    smp_ch.valid <= 1'b0;
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input smvz_pkg::reg_idx_e idx, input logic [15:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= smvz_pkg::PADDR_W'(4 * int'(idx)); pwdata <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == smvz_pkg::REG_HYP_MEAN) hyp_mean_q = value;
    else crit_q = value;
  endtask

  // Wait for all results, then let the back end settle before touching registers.
  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Result channel: for every item a drawn number of idle cycles, and a long hold when
  // requested.
  initial begin
    int unsigned wait_cycles;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_cycles = $urandom_range(0, 5);
      if (wait_cycles != 0 || hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
        while (hold_results) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
    end
  end

  // Long receiver hold, counted in its own process.
  task automatic hold_off_results(input int unsigned cycles);
    hold_results = 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_results = 1'b0;
  endtask

  // Result checker: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      zres_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("MISMATCH unexpected result item at %0t", $time);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.mean_value !== want.mean)
          report_mismatch("mean_value", res_ch.mean_value, want.mean);
        if (res_ch.sample_variance !== want.variance)
          report_mismatch("sample_variance", res_ch.sample_variance, want.variance);
        if (res_ch.z_magnitude !== want.zmag)
          report_mismatch("z_magnitude", res_ch.z_magnitude, want.zmag);
        if (res_ch.z_negative !== want.zneg)
          report_mismatch("z_negative", res_ch.z_negative, want.zneg);
        if (res_ch.reject_null !== want.reject)
          report_mismatch("reject_null", res_ch.reject_null, want.reject);
        if (res_ch.samples_used !== want.used)
          report_mismatch("samples_used", res_ch.samples_used, want.used);
        if (res_ch.status_code !== want.status)
          report_mismatch("status_code", res_ch.status_code, want.status);
      end
    end
  end

  // Directed stimulus table. Where a row carries a typed-in result, the checker's
  // expectation from the predictor is also compared against it.
  typedef struct {
    logic signed [15:0] x;
    bit                 last;
    bit                 has_want;
    smvz_pkg::status_e  want_status;
    logic signed [15:0] want_mean;
  } drow_t;

  drow_t directed_rows[] = '{
    // A lone sample: too few samples, mean is the sample itself.
    '{16'sh7FFF, 1'b1, 1'b1, smvz_pkg::ST_FEW, 16'sh7FFF},
    '{-16'sd32768, 1'b1, 1'b1, smvz_pkg::ST_FEW, -16'sd32768},
    // Two equal samples: zero variance.
    '{16'sd256, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{16'sd256, 1'b1, 1'b1, smvz_pkg::ST_ZERO_VAR, 16'sd256},
    // Extremes together: the largest variance.
    '{16'sh7FFF, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{-16'sd32768, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{16'sh7FFF, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{-16'sd32768, 1'b1, 1'b0, smvz_pkg::ST_OK, 0},
    // Small spread far from the hypothesis: the variance truncates to zero, so no z is computed.
    '{16'sh7FFF, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{16'sh7FFE, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{16'sh7FFF, 1'b1, 1'b0, smvz_pkg::ST_OK, 0},
    // Negative mean, here an exact -1.
    '{-16'sd1, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{-16'sd2, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{16'sd0, 1'b1, 1'b0, smvz_pkg::ST_OK, 0},
    // Mixed small values near zero.
    '{16'sd100, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{-16'sd90, 1'b0, 1'b0, smvz_pkg::ST_OK, 0},
    '{16'sd5, 1'b1, 1'b0, smvz_pkg::ST_OK, 0}
  };

  task automatic run_directed();
    zres_t tail;
    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].x, directed_rows[i].last, 1'b1);
      if (directed_rows[i].has_want) begin
        tail = expected_results[$];
        if (tail.status !== directed_rows[i].want_status ||
            tail.mean !== directed_rows[i].want_mean)
          report_mismatch("directed row", i, tail.status);
      end
    end
    idle_sender();
  endtask

  // A random data set: mostly sized so that results come often, some filling the store.
  task automatic send_random_set(input int unsigned n, input int unsigned style);
    logic signed [15:0] center, x;
    int unsigned spread;
    center = 16'($urandom);
    spread = 1 << $urandom_range(0, 15);
    for (int unsigned k = 0; k < n; k++) begin
      case (style)
        0: x = 16'($urandom);                                // full range noise
        1: x = center + $signed(16'($urandom_range(0, spread))) - 16'(spread / 2);
        default: x = center;                                 // constant set
      endcase
      send_sample(x, k == n - 1, 1'b1);
    end
  endtask

  task automatic random_phase(input int unsigned items_goal);
    int unsigned sent, n, pick;
    sent = 0;
    while (sent < items_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) n = $urandom_range(NMAX + 1, NMAX + 6);   // store overflow
      else if (pick < 6) n = NMAX;
      else if (pick < 10) n = $urandom_range(0, 1) + 1;
      else n = $urandom_range(2, 12);
      send_random_set(n, ($urandom_range(0, 9) == 0) ? 2 : (($urandom_range(0, 2) == 0) ? 0 : 1));
      sent += n;
    end
    idle_sender();
  endtask

  initial begin
    smp_ch.valid = 1'b0;
    smp_ch.sample = '0;
    smp_ch.last_sample = 1'b0;
    hold_results = 1'b0;
    set_count = 0; set_sum = 0; set_overflow = 1'b0;
    hyp_mean_q = smvz_pkg::HYP_MEAN_RESET;
    crit_q = smvz_pkg::CRIT_RESET;
    error_count = 0; results_seen = 0; sets_sent = 0;
    overflow_sets = 0; reject_sets = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values of the registers first.
    run_directed();
    drain();

    // Walk several register settings, the extremes among them.
    write_reg(smvz_pkg::REG_HYP_MEAN, 16'h7FFF);
    write_reg(smvz_pkg::REG_CRIT_VAL, 16'h0000);
    random_phase(250);
    drain();

    write_reg(smvz_pkg::REG_HYP_MEAN, 16'h8000);
    write_reg(smvz_pkg::REG_CRIT_VAL, 16'hFFFF);
    // The receiver holds off while sets keep arriving, so the core backs up.
    fork
      hold_off_results(4000);
      random_phase(250);
    join
    drain();

    write_reg(smvz_pkg::REG_HYP_MEAN, 16'($urandom));
    write_reg(smvz_pkg::REG_CRIT_VAL, 16'($urandom_range(0, 1024)));
    random_phase(400);
    drain();

    write_reg(smvz_pkg::REG_HYP_MEAN, 16'h0000);
    write_reg(smvz_pkg::REG_CRIT_VAL, smvz_pkg::CRIT_RESET);
    random_phase(400);
    drain();

    $display("Covered %0d data sets, %0d with store overflow, %0d rejecting the null.",
             sets_sent, overflow_sets, reject_sets);
    $display("Checked %0d result items with %0d mismatches.", results_seen, error_count);
    if (error_count == 0) begin
      $display("sample_mean_variance_z_test_core regression: pass");
    end else begin
      $display("sample_mean_variance_z_test_core regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(40_000_000);
    $display("Timeout with %0d result items still expected.", expected_results.size());
    $display("sample_mean_variance_z_test_core regression: fail");
    $finish;
  end
endmodule
